// ----- hw/rtl/b64enc_pkg.sv -----
// b64enc_pkg: shared types, constants and the alphabet lookup of the base64 encoder
// no dependencies
package b64enc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [6:0] PAD_CHAR  = 7'h3d;
    localparam logic [1:0] LAST_SLOT = 2'd3;
    localparam logic [1:0] FULL_CNT  = 2'd2;

    // one group of up to three bytes handed from front to back
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] nbytes;
        logic       eom;
    } group_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] c;
        case (v) inside
            [6'd0:6'd25]:  c = {1'b0, v} + 7'd65;
            [6'd26:6'd51]: c = {1'b0, v} + 7'd71;
            [6'd52:6'd61]: c = {1'b0, v} - 7'd4;
            6'd62:         c = 7'h2b;
            default:       c = 7'h2f;
        endcase
        return c;
    endfunction

    function automatic logic [5:0] group_sextet(input group_t g, input logic [1:0] slot);
        logic [5:0] s;
        case (slot)
            2'd0:    s = g.b0[7:2];
            2'd1:    s = {g.b0[1:0], g.b1[7:4]};
            2'd2:    s = {g.b1[3:0], g.b2[7:6]};
            default: s = g.b2[5:0];
        endcase
        return s;
    endfunction

endpackage

// ----- hw/rtl/b64enc_byte_if.sv -----
// b64enc_byte_if: input channel of the base64 encoder, one raw byte per word
// no dependencies
interface b64enc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

// ----- hw/rtl/b64enc_char_if.sv -----
// b64enc_char_if: output channel of the base64 encoder, one ascii character per word
// no dependencies
interface b64enc_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] ascii_char;
    logic       last_of_run;
    logic       message_done;

    modport source (output valid, output ascii_char, output last_of_run,
                    output message_done, input ready);
    modport sink (input valid, input ascii_char, input last_of_run,
                  input message_done, output ready);
endinterface

// ----- hw/rtl/b64enc_front.sv -----
// b64enc_front: collects input bytes into groups of three and flushes at end of message
// depends on b64enc_pkg, b64enc_byte_if
module b64enc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    b64enc_byte_if.sink          in_ch,
    output logic                 push_valid,
    input  logic                 push_ready,
    output b64enc_pkg::group_t   push_data
);
    import b64enc_pkg::*;

    logic [7:0] pend0_reg;
    logic [7:0] pend1_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       accept;

    assign in_ch.ready = push_ready;
    assign accept      = in_ch.valid && push_ready;
    assign push_valid  = in_ch.valid && ((cnt_reg == FULL_CNT) || in_ch.end_of_message);

    always_comb
    begin
        push_data.eom = in_ch.end_of_message;
        push_data.b2  = 8'd0;
        if (cnt_reg == FULL_CNT)
        begin
            push_data.b0     = pend0_reg;
            push_data.b1     = pend1_reg;
            push_data.b2     = in_ch.data_byte;
            push_data.nbytes = 2'd3;
        end
        else if (cnt_reg == 2'd1)
        begin
            push_data.b0     = pend0_reg;
            push_data.b1     = in_ch.data_byte;
            push_data.nbytes = 2'd2;
        end
        else
        begin
            push_data.b0     = in_ch.data_byte;
            push_data.b1     = 8'd0;
            push_data.nbytes = 2'd1;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (push_valid)
                cnt_next = 2'd0;
            else
                cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    // pending bytes only hold payload
    always_ff @(posedge clk)
    begin
        if (accept && !push_valid)
        begin
            if (cnt_reg[0])
                pend1_reg <= in_ch.data_byte;
            else
                pend0_reg <= in_ch.data_byte;
        end
    end

endmodule

// ----- hw/rtl/b64enc_queue.sv -----
// b64enc_queue: short group queue between front and back
// depends on b64enc_pkg
module b64enc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  b64enc_pkg::group_t   push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output b64enc_pkg::group_t   pop_data
);
    import b64enc_pkg::*;

    localparam logic [QUEUE_AW:0] DEPTH_CNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    group_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   fill_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (fill_reg != DEPTH_CNT);
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- hw/rtl/b64enc_back.sv -----
// b64enc_back: turns each queued group into four characters through an output register
// depends on b64enc_pkg, b64enc_char_if
module b64enc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  b64enc_pkg::group_t   pop_data,
    b64enc_char_if.source        out_ch
);
    import b64enc_pkg::*;

    logic [1:0] slot_reg;
    logic       valid_reg;
    logic [6:0] char_reg;
    logic       last_reg;
    logic       done_reg;
    logic       load;
    logic       is_last;
    logic [6:0] char_next;

    assign load      = pop_valid && (!valid_reg || out_ch.ready);
    assign is_last   = (slot_reg == LAST_SLOT);
    assign pop_ready = load && is_last;

    // slots past the byte count are padding
    assign char_next = (slot_reg > pop_data.nbytes) ? PAD_CHAR
                                                    : sextet_char(group_sextet(pop_data, slot_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                slot_reg  <= slot_reg + 2'd1;
                valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= char_next;
            last_reg <= is_last;
            done_reg <= is_last && pop_data.eom;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.ascii_char   = char_reg;
    assign out_ch.last_of_run  = last_reg;
    assign out_ch.message_done = done_reg;

endmodule

// ----- hw/rtl/base64_stream_encoder.sv -----
// base64_stream_encoder: top level of the streaming base64 encoder
// depends on b64enc_pkg, b64enc_byte_if, b64enc_char_if, b64enc_front, b64enc_queue, b64enc_back
//
// usage
//   in_ch takes one raw byte per word with end_of_message on the last byte of a message
//   out_ch gives one ascii character per word, standard alphabet plus '=' padding
//   every third byte, and every byte flagged end_of_message, releases four characters;
//   last_of_run marks the fourth, message_done marks it when the group closed a message
// data path
//   a byte that closes a group is written into the group queue at the accepting edge;
//   its first character then loads into the output register once the back end is free
// throughput
//   the back end emits one character per cycle while a group waits and out_ch is ready
//   in_ch is ready whenever the two-entry group queue has room, also while a character
//   waits in the output register
// reset
//   clears the byte count, the queue pointers and the output valid; pending bytes are
//   payload only and need no reset
// stall
//   when out_ch is not ready the character holds, the back end stops, the queue fills,
//   and in_ch drops ready once both queue entries hold groups
module base64_stream_encoder (
    input  logic          clk,
    input  logic          rst_n,
    b64enc_byte_if.sink   in_ch,
    b64enc_char_if.source out_ch
);
    import b64enc_pkg::*;

    // front to queue
    logic   push_valid;
    logic   push_ready;
    group_t push_data;

    // queue to back
    logic   pop_valid;
    logic   pop_ready;
    group_t pop_data;

    // grouping of bytes and end-of-message flush
    b64enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decouples byte intake from character output
    b64enc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // sextet split, alphabet lookup and padding, one character a cycle while a group waits and out_ch is ready
    b64enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_ch    (out_ch)
    );

endmodule

// ----- hw/rtl/b64enc_checker.sv -----
// b64enc_checker: port-level checks of the base64 encoder, bound to the top level
// depends on b64enc_pkg, base64_stream_encoder
module b64enc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] ascii_char,
    input logic       last_of_run,
    input logic       message_done
);
    import b64enc_pkg::*;

    logic char_legal;

    assign char_legal = (ascii_char >= 7'h41 && ascii_char <= 7'h5a) ||
                        (ascii_char >= 7'h61 && ascii_char <= 7'h7a) ||
                        (ascii_char >= 7'h30 && ascii_char <= 7'h39) ||
                        (ascii_char == 7'h2b) || (ascii_char == 7'h2f) ||
                        (ascii_char == PAD_CHAR);

    a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_stall_holds_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(ascii_char) && $stable(last_of_run))
        else $error("output word changed while stalled");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_done |-> last_of_run)
        else $error("message_done without last_of_run");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> char_legal)
        else $error("character outside the base64 alphabet");

    // padding runs to the end of the group: an accepted pad that does not close the group is followed by a pad
    a_pad_tail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (ascii_char == PAD_CHAR) && !last_of_run ##1 out_valid
        |-> (ascii_char == PAD_CHAR))
        else $error("alphabet character after padding within a group");

endmodule

bind base64_stream_encoder b64enc_checker u_b64enc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .ascii_char   (out_ch.ascii_char),
    .last_of_run  (out_ch.last_of_run),
    .message_done (out_ch.message_done)
);

// ----- tb/b64enc_checker.sv -----
`timescale 1ns / 100ps
// b64enc_scoreboard: watches both channels of the base64 encoder, predicts every character
// and compares it with what the encoder delivers; depends on b64enc_pkg and the two channel
// interfaces
module b64enc_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    b64enc_byte_if      in_ch,
    b64enc_char_if      out_ch,
    output int unsigned mismatches,
    output int unsigned chars_owed
);
    import b64enc_pkg::*;

    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [6:0] ascii_char;
        logic       last_of_run;
        logic       message_done;
    } enc_char_t;

    enc_char_t   expected_chars[$];
    logic [7:0]  held_bytes[2];
    logic [1:0]  held_count;

    // one byte in, zero or four characters expected out
    task automatic encode_word(input logic [7:0] b, input logic eom);
        logic [23:0] grp;
        int          nbytes;
        logic [5:0]  sx;
        enc_char_t   c;
        nbytes = 0;
        grp    = '0;
        if (held_count == 2'd2)
        begin
            grp        = {held_bytes[0], held_bytes[1], b};
            nbytes     = 3;
            held_count = 2'd0;
        end
        else
        begin
            held_bytes[held_count[0]] = b;
            held_count = held_count + 2'd1;
            if (eom)
            begin
                grp    = {held_bytes[0], (held_count == 2'd2) ? held_bytes[1] : 8'h00, 8'h00};
                nbytes = int'(held_count);
            end
        end
        if (eom)
            held_count = 2'd0;
        if (nbytes > 0)
        begin
            for (int k = 0; k < 4; k++)
            begin
                sx = grp[23 - 6*k -: 6];
                if (k <= nbytes)
                    c.ascii_char = ALPHABET[8*(63 - sx) +: 7];
                else
                    c.ascii_char = PAD_CHAR;
                c.last_of_run  = (k == 3);
                c.message_done = (k == 3) && eom;
                expected_chars.push_back(c);
            end
        end
    endtask

    task automatic report(input string what, input logic [6:0] want, input logic [6:0] got);
        mismatches++;
        $display("%0t mismatch %s: expected %h, actual %h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        enc_char_t want;
        if (!rst_n)
        begin
            expected_chars.delete();
            held_count = 2'd0;
            mismatches = 0;
        end
        else
        begin
            // compare before predicting: a new byte cannot show up in the same cycle
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected word: expected none, actual %h/%b/%b", $time,
                             out_ch.ascii_char, out_ch.last_of_run, out_ch.message_done);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_ch.ascii_char !== want.ascii_char)
                        report("ascii_char", want.ascii_char, out_ch.ascii_char);
                    if (out_ch.last_of_run !== want.last_of_run)
                        report("last_of_run", 7'(want.last_of_run), 7'(out_ch.last_of_run));
                    if (out_ch.message_done !== want.message_done)
                        report("message_done", 7'(want.message_done),
                               7'(out_ch.message_done));
                end
            end
            if (in_ch.valid && in_ch.ready)
                encode_word(in_ch.data_byte, in_ch.end_of_message);
        end
        chars_owed = unsigned'(expected_chars.size());
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// testbench: stimulus and verdict for base64_stream_encoder
// depends on b64enc_pkg, the channel interfaces, the encoder and b64enc_scoreboard
module testbench;

    localparam int RANDOM_WORDS = 250;

    logic        clk;
    logic        rst_n;
    // while high neither side idles, a long back-to-back stretch
    logic        steady;
    int unsigned mismatches;
    int unsigned chars_owed;

    b64enc_byte_if byte_ch();
    b64enc_char_if char_ch();

    base64_stream_encoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (byte_ch),
        .out_ch (char_ch)
    );

    // prediction and comparison live in the scoreboard; the top only drives and judges
    b64enc_scoreboard checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (byte_ch),
        .out_ch     (char_ch),
        .mismatches (mismatches),
        .chars_owed (chars_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver: drops ready about 23 percent of the time, never during the steady stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            char_ch.ready <= 1'b0;
        else
            char_ch.ready <= steady || ($urandom_range(99) >= 23);
    end

    // send one byte: random idle cycles first, then hold valid until the word is taken
    task automatic send_word(input logic [7:0] b, input logic eom);
        while (!steady && $urandom_range(99) < 23)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid          <= 1'b1;
        byte_ch.data_byte      <= b;
        byte_ch.end_of_message <= eom;
        do
            @(posedge clk);
        while (!byte_ch.ready);
    endtask

    initial
    begin
        int sent;
        int msg_len;
        byte_ch.valid          <= 1'b0;
        byte_ch.data_byte      <= 8'h00;
        byte_ch.end_of_message <= 1'b0;
        steady                 <= 1'b0;
        rst_n                  <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-byte messages at both extremes: two characters and "=="
        send_word(8'h00, 1'b1);
        send_word(8'hff, 1'b1);
        // two-byte messages: three characters and "="
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b1);
        send_word(8'hff, 1'b0);
        send_word(8'h00, 1'b1);
        // a message ending on a full group, every sextet 62 so all '+'
        send_word(8'hfb, 1'b0);
        send_word(8'hef, 1'b0);
        send_word(8'hbe, 1'b1);
        // full group of ones gives all '/', ends the message with no padding
        send_word(8'hff, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'hff, 1'b1);
        // one full group mid-message, then a single leftover byte at the end
        send_word(8'h4d, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(8'h6e, 1'b0);
        send_word(8'h4d, 1'b1);

        // random messages, mostly short, now and then a long one
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (sent >= 100 && sent < 170)
                steady <= 1'b1;
            else
                steady <= 1'b0;
            if ($urandom_range(9) == 0)
                msg_len = $urandom_range(30, 10);
            else
                msg_len = $urandom_range(9, 1);
            for (int i = 0; i < msg_len; i++)
                send_word(8'($urandom_range(255)), i == msg_len - 1);
            sent += msg_len;
        end
        byte_ch.valid <= 1'b0;
        steady        <= 1'b0;

        // drain the characters still owed, then let the encoder idle before the verdict
        while (chars_owed != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && chars_owed == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
